// File: design/gbwm_pkg.sv
// gbwm_pkg: shared constants, widths and types of the grid bilinear warp map
// used by the front, queue, back and top level; no dependencies

package gbwm_pkg;

  // grid and pixel sizing
  localparam int MAX_GRID_COLS = 64;
  localparam int MAX_GRID_ROWS = 64;
  localparam int PIXEL_BITS    = 12;
  localparam int STORE_DEPTH   = MAX_GRID_COLS * MAX_GRID_ROWS;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  // widths of the column/row counts and of the cell indexes
  localparam int CN_W  = $clog2(MAX_GRID_COLS + 1);
  localparam int RN_W  = $clog2(MAX_GRID_ROWS + 1);
  localparam int N_W   = (CN_W > RN_W) ? CN_W : RN_W;
  localparam int COL_W = $clog2(MAX_GRID_COLS);
  localparam int ROW_W = $clog2(MAX_GRID_ROWS);
  localparam int IX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SI_W  = N_W + 2;

  // fixed point
  localparam int FRAC_BITS  = 16;
  localparam int ROUND      = 32768;
  localparam int FRAC_LIMIT = 1048576;
  localparam int P_W        = 22;
  localparam int DX_W       = PIXEL_BITS + 10;
  localparam int PROD_W     = DX_W + 17;
  localparam int RX_W       = PROD_W - 8;
  localparam int HI_W       = RX_W - FRAC_BITS;

  // queue between front and back
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_INV_X        = 3'd2,
    REG_INV_Y        = 3'd3,
    REG_GRID_COLS    = 3'd4,
    REG_GRID_ROWS    = 3'd5,
    REG_REGION_COUNT = 3'd6
  } cfg_reg_t;

  // geometry as seen by the datapath, counts already clamped
  typedef struct packed {
    logic [20:0]     origin_x;
    logic [20:0]     origin_y;
    logic [15:0]     inv_x;
    logic [15:0]     inv_y;
    logic [CN_W-1:0] cols;
    logic [RN_W-1:0] rows;
    logic            seam_x;
    logic            seam_y;
  } geom_t;

  // one classified item between front and back
  typedef struct packed {
    logic              is_map;
    logic              wen;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wx;
    logic [31:0]       wy;
    logic [ADDR_W-1:0] base;
    logic [P_W-1:0]    p;
    logic [P_W-1:0]    q;
  } job_t;

endpackage

// File: design/gbwm_front.sv
// gbwm_front: three-stage front end; origin subtract, spacing scale, cell pick
// depends on gbwm_pkg; hands classified beats to gbwm_queue by credit

module gbwm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [11:0]                      grid_index,
  input  logic [31:0]                      grid_x_cm,
  input  logic [31:0]                      grid_y_cm,
  input  logic [gbwm_pkg::PIXEL_BITS-1:0]  pixel_x,
  input  logic [gbwm_pkg::PIXEL_BITS-1:0]  pixel_y,
  input  gbwm_pkg::geom_t                  geom,
  input  logic [gbwm_pkg::QC_W-1:0]        q_count,
  output logic                             job_valid,
  output gbwm_pkg::job_t                   job
);
  import gbwm_pkg::*;

  typedef struct packed {
    logic [IX_W-1:0] idx;
    logic [P_W-1:0]  frac;
  } cell_t;

  // clamp to the grid, shift off the seam, keep the fraction
  function automatic cell_t cell_of(input logic signed [RX_W-1:0] r,
                                    input logic [N_W-1:0] n,
                                    input logic seam);
    logic signed [HI_W-1:0] hi;
    logic signed [SI_W-1:0] i;
    logic signed [SI_W-1:0] nn;
    logic signed [SI_W-1:0] h2;
    logic signed [RX_W:0]   pw;
    cell_t                  c;
    hi = r[RX_W-1:FRAC_BITS];
    nn = SI_W'(n);
    h2 = nn >>> 1;
    if (r < 0) begin
      i = SI_W'(0);
    end else if (hi < HI_W'(nn - SI_W'(1))) begin
      i = SI_W'(hi);
    end else begin
      i = nn - SI_W'(2);
    end
    if (seam) begin
      if (i == h2 - SI_W'(1)) begin
        i = i - SI_W'(1);
      end else if (i == h2) begin
        i = i + SI_W'(1);
      end
      // a shift below cell 0 comes back to cell 0
      if (i[SI_W-1]) begin
        i = SI_W'(0);
      end
      if (i > nn - SI_W'(2)) begin
        i = nn - SI_W'(2);
      end
    end
    pw = (RX_W+1)'(r) - ((RX_W+1)'(i) <<< FRAC_BITS);
    if (pw > (RX_W+1)'(FRAC_LIMIT)) begin
      pw = (RX_W+1)'(FRAC_LIMIT);
    end else if (pw < -(RX_W+1)'(FRAC_LIMIT)) begin
      pw = -(RX_W+1)'(FRAC_LIMIT);
    end
    c.idx  = i[IX_W-1:0];
    c.frac = pw[P_W-1:0];
    return c;
  endfunction

  logic                     accept;
  logic [QC_W:0]            in_use;
  logic [31:0]              gi_ext;

  logic                     f1_v, f1_map, f1_wen;
  logic [ADDR_W-1:0]        f1_waddr;
  logic [31:0]              f1_wx, f1_wy;
  logic signed [DX_W-1:0]   f1_dx, f1_dy;

  logic                     f2_v, f2_map, f2_wen;
  logic [ADDR_W-1:0]        f2_waddr;
  logic [31:0]              f2_wx, f2_wy;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [RX_W-1:0]   f2_rx, f2_ry;

  cell_t                    cx, cy;

  // credit: queue entries plus beats still in the front
  assign in_use   = (QC_W+1)'(q_count) + (QC_W+1)'(f1_v) + (QC_W+1)'(f2_v)
                  + (QC_W+1)'(job_valid);
  assign in_stall = (in_use >= (QC_W+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign gi_ext   = 32'(grid_index);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v      <= 1'b0;
      f2_v      <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      f1_v      <= accept;
      f2_v      <= f1_v;
      job_valid <= f2_v;
    end
  end

  // stage 1: pixel minus origin, both with 8 fraction bits
  always_ff @(posedge clk) begin
    f1_map   <= func;
    f1_wen   <= !func && (gi_ext < 32'(STORE_DEPTH));
    f1_waddr <= gi_ext[ADDR_W-1:0];
    f1_wx    <= grid_x_cm;
    f1_wy    <= grid_y_cm;
    f1_dx    <= $signed({2'b00, pixel_x, 8'h00}) - DX_W'($signed(geom.origin_x));
    f1_dy    <= $signed({2'b00, pixel_y, 8'h00}) - DX_W'($signed(geom.origin_y));
  end

  // stage 2: scale by reciprocal spacing
  assign prod_x = f1_dx * $signed({1'b0, geom.inv_x});
  assign prod_y = f1_dy * $signed({1'b0, geom.inv_y});

  always_ff @(posedge clk) begin
    f2_map   <= f1_map;
    f2_wen   <= f1_wen;
    f2_waddr <= f1_waddr;
    f2_wx    <= f1_wx;
    f2_wy    <= f1_wy;
    f2_rx    <= $signed(prod_x[PROD_W-1:8]);
    f2_ry    <= $signed(prod_y[PROD_W-1:8]);
  end

  // stage 3: cell index, fraction and base address
  assign cx = cell_of(f2_rx, N_W'(geom.cols), geom.seam_x);
  assign cy = cell_of(f2_ry, N_W'(geom.rows), geom.seam_y);

  always_ff @(posedge clk) begin
    job.is_map <= f2_map;
    job.wen    <= f2_wen;
    job.waddr  <= f2_waddr;
    job.wx     <= f2_wx;
    job.wy     <= f2_wy;
    job.base   <= ADDR_W'(cy.idx) * ADDR_W'(geom.cols) + ADDR_W'(cx.idx);
    job.p      <= cx.frac;
    job.q      <= cy.frac;
  end

endmodule

// File: design/gbwm_queue.sv
// gbwm_queue: short fifo of classified beats between front and back
// depends on gbwm_pkg for the beat type and depth

module gbwm_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  gbwm_pkg::job_t            din,
  input  logic                      pop,
  output gbwm_pkg::job_t            dout,
  output logic                      not_empty,
  output logic [gbwm_pkg::QC_W-1:0] count
);
  import gbwm_pkg::*;

  job_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign not_empty = (count != '0);
  assign dout      = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QC_W'(1);
      end else if (!push && pop) begin
        count <= count - QC_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

// File: design/gbwm_back.sv
// gbwm_back: grid store and five-stage bilinear blend with output register
// depends on gbwm_pkg; pops beats from gbwm_queue

module gbwm_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [gbwm_pkg::CN_W-1:0] cols,
  input  logic                      job_ready,
  input  gbwm_pkg::job_t            job,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               x_cm,
  output logic [31:0]               y_cm
);
  import gbwm_pkg::*;

  localparam int D_W  = 33;
  localparam int M1_W = D_W + P_W;
  localparam int C_W  = 40;
  localparam int E_W  = C_W + 1;
  localparam int M2_W = E_W + P_W;
  localparam int S_W  = M2_W - FRAC_BITS + 1;
  localparam logic signed [S_W-1:0] SAT_HI = S_W'($signed(32'h7FFF_FFFF));
  localparam logic signed [S_W-1:0] SAT_LO = S_W'($signed(32'h8000_0000));

  // two copies of the store, each read at two addresses; word is {y, x}
  logic [63:0]        mem_a [STORE_DEPTH];
  logic [63:0]        mem_b [STORE_DEPTH];
  logic [63:0]        rd_00, rd_01, rd_10, rd_11;
  logic [ADDR_W-1:0]  a_00, a_01, a_10, a_11;

  logic               adv;
  logic               b1_v, b2_v, b3_v, b4_v;
  logic [P_W-1:0]     b1_p, b1_q, b2_p, b3_p;

  logic signed [D_W-1:0]  d0 [2];
  logic signed [D_W-1:0]  d1 [2];
  logic signed [31:0]     v00 [2];
  logic signed [31:0]     v01 [2];
  logic signed [31:0]     v10 [2];
  logic signed [31:0]     v11 [2];
  logic signed [31:0]     b2_a0 [2];
  logic signed [31:0]     b2_a1 [2];
  logic signed [M1_W-1:0] b2_m0 [2];
  logic signed [M1_W-1:0] b2_m1 [2];
  logic signed [C_W-1:0]  b3_c0 [2];
  logic signed [C_W-1:0]  b3_c1 [2];
  logic signed [E_W-1:0]  e [2];
  logic signed [C_W-1:0]  b4_c0 [2];
  logic signed [M2_W-1:0] b4_m [2];
  logic signed [S_W-1:0]  s [2];
  logic [31:0]            sat [2];

  // the whole back moves together; the output register holds when stalled
  assign adv = !out_valid || !out_stall;
  assign pop = adv && job_ready;

  assign a_00 = job.base;
  assign a_01 = job.base + ADDR_W'(1);
  assign a_10 = job.base + ADDR_W'(cols);
  assign a_11 = a_10 + ADDR_W'(1);

  // stage 1: store write for load beats, four neighbour reads for map beats
  always_ff @(posedge clk) begin
    if (pop && job.wen) begin
      mem_a[job.waddr] <= {job.wy, job.wx};
      mem_b[job.waddr] <= {job.wy, job.wx};
    end
    if (adv) begin
      rd_00 <= mem_a[a_00];
      rd_01 <= mem_a[a_01];
      rd_10 <= mem_b[a_10];
      rd_11 <= mem_b[a_11];
      b1_p  <= job.p;
      b1_q  <= job.q;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      b3_v      <= 1'b0;
      b4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b1_v      <= pop && job.is_map;
      b2_v      <= b1_v;
      b3_v      <= b2_v;
      b4_v      <= b3_v;
      out_valid <= b4_v;
    end
  end

  // lane split: lane 0 is x, lane 1 is y
  always_comb begin
    v00[0] = $signed(rd_00[31:0]);
    v00[1] = $signed(rd_00[63:32]);
    v01[0] = $signed(rd_01[31:0]);
    v01[1] = $signed(rd_01[63:32]);
    v10[0] = $signed(rd_10[31:0]);
    v10[1] = $signed(rd_10[63:32]);
    v11[0] = $signed(rd_11[31:0]);
    v11[1] = $signed(rd_11[63:32]);
    for (int l = 0; l < 2; l++) begin
      d0[l] = D_W'(v10[l]) - D_W'(v00[l]);
      d1[l] = D_W'(v11[l]) - D_W'(v01[l]);
      e[l]  = E_W'(b3_c1[l]) - E_W'(b3_c0[l]);
      s[l]  = S_W'(b4_c0[l]) + S_W'((b4_m[l] + M2_W'(ROUND)) >>> FRAC_BITS);
      if (s[l] > SAT_HI) begin
        sat[l] = 32'h7FFF_FFFF;
      end else if (s[l] < SAT_LO) begin
        sat[l] = 32'h8000_0000;
      end else begin
        sat[l] = s[l][31:0];
      end
    end
  end

  // stages 2 to 5: column blend along q, then row blend along p
  always_ff @(posedge clk) begin
    if (adv) begin
      b2_p <= b1_p;
      b3_p <= b2_p;
      for (int l = 0; l < 2; l++) begin
        b2_a0[l] <= v00[l];
        b2_a1[l] <= v01[l];
        b2_m0[l] <= d0[l] * $signed(b1_q);
        b2_m1[l] <= d1[l] * $signed(b1_q);
        b3_c0[l] <= C_W'(b2_a0[l]) + C_W'((b2_m0[l] + M1_W'(ROUND)) >>> FRAC_BITS);
        b3_c1[l] <= C_W'(b2_a1[l]) + C_W'((b2_m1[l] + M1_W'(ROUND)) >>> FRAC_BITS);
        b4_c0[l] <= b3_c0[l];
        b4_m[l]  <= e[l] * $signed(b3_p);
      end
      x_cm <= sat[0];
      y_cm <= sat[1];
    end
  end

endmodule

// File: design/grid_bilinear_warp_map.sv
// grid_bilinear_warp_map: top level; configuration registers, front, queue, back
// depends on gbwm_pkg, gbwm_front, gbwm_queue and gbwm_back
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  func grid_index grid_x_cm grid_y_cm pixel_x pixel_y
//   result    out        out_valid / out_stall x_cm y_cm (one per map beat, none per load)
//   config    in         cfg_we               cfg_index cfg_data
//
// One beat is taken every cycle while in_stall is low; a map beat's result then passes
// the two remaining front stages, the queue and the 5 back stages before it is offered.
// Rate is set by the one write and two reads per cycle on each grid store copy. The
// front stalls only when the queue entries plus the beats in its own stages reach the
// 8-entry queue depth. Synchronous reset clears control state; the grid store is not cleared.

module grid_bilinear_warp_map (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [20:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [11:0]                      grid_index,
  input  logic [31:0]                      grid_x_cm,
  input  logic [31:0]                      grid_y_cm,
  input  logic [gbwm_pkg::PIXEL_BITS-1:0]  pixel_x,
  input  logic [gbwm_pkg::PIXEL_BITS-1:0]  pixel_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      x_cm,
  output logic [31:0]                      y_cm
);
  import gbwm_pkg::*;

  logic [20:0]     origin_x, origin_y;
  logic [15:0]     inv_x, inv_y;
  logic [6:0]      grid_cols, grid_rows;
  logic [2:0]      region_count;
  geom_t           geom;

  logic            job_valid;
  job_t            job_in, job_out;
  logic            q_ne, q_pop;
  logic [QC_W-1:0] q_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      inv_x        <= 16'hFFFF;
      inv_y        <= 16'hFFFF;
      grid_cols    <= 7'd64;
      grid_rows    <= 7'd64;
      region_count <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:     origin_x     <= cfg_data;
        REG_ORIGIN_Y:     origin_y     <= cfg_data;
        REG_INV_X:        inv_x        <= cfg_data[15:0];
        REG_INV_Y:        inv_y        <= cfg_data[15:0];
        REG_GRID_COLS:    grid_cols    <= cfg_data[6:0];
        REG_GRID_ROWS:    grid_rows    <= cfg_data[6:0];
        REG_REGION_COUNT: region_count <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // clamp grid size, decode seam handling
  always_comb begin
    geom.origin_x = origin_x;
    geom.origin_y = origin_y;
    geom.inv_x    = inv_x;
    geom.inv_y    = inv_y;
    if (grid_cols < 7'd2) begin
      geom.cols = CN_W'(2);
    end else if (32'(grid_cols) > 32'(MAX_GRID_COLS)) begin
      geom.cols = CN_W'(MAX_GRID_COLS);
    end else begin
      geom.cols = CN_W'(grid_cols);
    end
    if (grid_rows < 7'd2) begin
      geom.rows = RN_W'(2);
    end else if (32'(grid_rows) > 32'(MAX_GRID_ROWS)) begin
      geom.rows = RN_W'(MAX_GRID_ROWS);
    end else begin
      geom.rows = RN_W'(grid_rows);
    end
    geom.seam_x = (region_count >= 3'd2);
    geom.seam_y = (region_count == 3'd4);
  end

  gbwm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .grid_index (grid_index),
    .grid_x_cm  (grid_x_cm),
    .grid_y_cm  (grid_y_cm),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .geom       (geom),
    .q_count    (q_count),
    .job_valid  (job_valid),
    .job        (job_in)
  );

  gbwm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .din       (job_in),
    .pop       (q_pop),
    .dout      (job_out),
    .not_empty (q_ne),
    .count     (q_count)
  );

  gbwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cols      (geom.cols),
    .job_ready (q_ne),
    .job       (job_out),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_cm      (x_cm),
    .y_cm      (y_cm)
  );

endmodule

// File: design/gbwm_checker.sv
// gbwm_checker: port-level checks of the warp map, bound to the top level
// depends only on the top level's ports

module gbwm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] x_cm,
  input logic [31:0] y_cm
);

  logic [5:0] pending;
  logic       map_in, res_out;

  assign map_in  = in_valid && !in_stall && func;
  assign res_out = out_valid && !out_stall;

  // map beats taken and not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 6'(map_in) - 6'(res_out);
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(x_cm) && $stable(y_cm))
    else $error("result changed while stalled");

  // reset leaves no result and an open input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state left over after reset");

  // every result answers a map beat; load beats give none
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 6'd0)
    else $error("result without a pending map beat");

endmodule

bind grid_bilinear_warp_map gbwm_checker u_gbwm_checker (.*);

// File: sim/tb_grid_bilinear_warp_map.sv
// tb_grid_bilinear_warp_map: self-checking testbench of the grid bilinear warp map
// depends on gbwm_pkg and grid_bilinear_warp_map; fills the low grid points, then runs
// map beats under several geometry settings with random bursts and receiver stalls

module tb_grid_bilinear_warp_map;
  import gbwm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int NUM_PHASES     = 11;
  localparam int FILL_DEPTH     = 256;
  localparam int RANDOM_BEATS   = 45;

  // expected-result store with its own copy of the grid and the geometry
  class warp_scoreboard;
    logic [31:0] grid_x [STORE_DEPTH];
    logic [31:0] grid_y [STORE_DEPTH];
    logic [20:0] org_x, org_y;
    logic [15:0] inv_x, inv_y;
    logic [6:0]  cols_r, rows_r;
    logic [2:0]  regions;
    logic [31:0] want_x [$];
    logic [31:0] want_y [$];
    int mismatches, loads, maps, matched;

    function new();
      org_x = '0;
      org_y = '0;
      inv_x = 16'hFFFF;
      inv_y = 16'hFFFF;
      cols_r = 7'd64;
      rows_r = 7'd64;
      regions = 3'd1;
    endfunction

    function void set_reg(cfg_reg_t r, logic [20:0] d);
      case (r)
        REG_ORIGIN_X: org_x = d;
        REG_ORIGIN_Y: org_y = d;
        REG_INV_X: inv_x = d[15:0];
        REG_INV_Y: inv_y = d[15:0];
        REG_GRID_COLS: cols_r = d[6:0];
        REG_GRID_ROWS: rows_r = d[6:0];
        REG_REGION_COUNT: regions = d[2:0];
        default: ;
      endcase
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // cell index from a 16-fraction coordinate
    function longint cell_of(longint r, longint n);
      if (r < 0) return 0;
      if (r < ((n - 1) <<< 16)) return r >>> 16;
      return n - 2;
    endfunction

    // move cells next to the central seam away from it
    function longint off_seam(longint i, longint n);
      if (i == n / 2 - 1) i = i - 1;
      else if (i == n / 2) i = i + 1;
      return clampl(i, 0, n - 2);
    endfunction

    // rounding half up
    function longint lerp(longint a, longint b, longint f);
      return a + (((b - a) * f + 32768) >>> 16);
    endfunction

    function logic [31:0] blend(bit use_y, longint base, longint n, longint p, longint q);
      longint v00, v01, v10, v11, c0, c1;
      v00 = use_y ? longint'($signed(grid_y[base])) : longint'($signed(grid_x[base]));
      v01 = use_y ? longint'($signed(grid_y[base + 1])) : longint'($signed(grid_x[base + 1]));
      v10 = use_y ? longint'($signed(grid_y[base + n])) : longint'($signed(grid_x[base + n]));
      v11 = use_y ? longint'($signed(grid_y[base + n + 1]))
                  : longint'($signed(grid_x[base + n + 1]));
      c0 = lerp(v00, v10, q);
      c1 = lerp(v01, v11, q);
      return 32'(clampl(lerp(c0, c1, p), -64'sd2147483648, 64'sd2147483647));
    endfunction

    function void note_input(logic f, logic [11:0] gi, logic [31:0] gx, logic [31:0] gy,
                             logic [11:0] px, logic [11:0] py);
      longint n_c, n_r, dx, dy, rx, ry, ix, iy, p, q, base;
      if (!f) begin
        grid_x[gi] = gx;
        grid_y[gi] = gy;
        loads++;
        return;
      end
      maps++;
      n_c = clampl(longint'(cols_r), 2, MAX_GRID_COLS);
      n_r = clampl(longint'(rows_r), 2, MAX_GRID_ROWS);
      dx = (longint'(px) <<< 8) - longint'($signed(org_x));
      dy = (longint'(py) <<< 8) - longint'($signed(org_y));
      rx = (dx * longint'(inv_x)) >>> 8;
      ry = (dy * longint'(inv_y)) >>> 8;
      ix = cell_of(rx, n_c);
      iy = cell_of(ry, n_r);
      if (regions >= 3'd2) ix = off_seam(ix, n_c);
      if (regions == 3'd4) iy = off_seam(iy, n_r);
      p = clampl(rx - ix * 65536, -FRAC_LIMIT, FRAC_LIMIT);
      q = clampl(ry - iy * 65536, -FRAC_LIMIT, FRAC_LIMIT);
      base = iy * n_c + ix;
      want_x.push_back(blend(0, base, n_c, p, q));
      want_y.push_back(blend(1, base, n_c, p, q));
    endfunction

    function void report(string what, logic [31:0] e, logic [31:0] a);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h got %h", what, e, a);
    endfunction

    function void check(logic [31:0] x, logic [31:0] y);
      logic [31:0] ex, ey;
      if (want_x.size() == 0) begin
        report("unexpected result x_cm", 'x, x);
        return;
      end
      ex = want_x.pop_front();
      ey = want_y.pop_front();
      if (x !== ex) report("x_cm", ex, x);
      if (y !== ey) report("y_cm", ey, y);
      if (x === ex && y === ey) matched++;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [20:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        func = 0;
  logic [11:0] grid_index = '0;
  logic [31:0] grid_x_cm = '0;
  logic [31:0] grid_y_cm = '0;
  logic [PIXEL_BITS-1:0] pixel_x = '0;
  logic [PIXEL_BITS-1:0] pixel_y = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] x_cm, y_cm;

  warp_scoreboard sb = new();
  int quiet_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;

  grid_bilinear_warp_map u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .grid_index(grid_index), .grid_x_cm(grid_x_cm), .grid_y_cm(grid_y_cm),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_stall(out_stall), .x_cm(x_cm), .y_cm(y_cm)
  );

  always #2 clk = ~clk;

  // result side: check beats, stall in segments, watch for a hang
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check(x_cm, y_cm);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_mode == 2) out_stall <= ($urandom_range(0, 1) == 1);
    end else begin
      stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: begin
          out_stall <= 0;
          stall_left <= $urandom_range(1, 40);
        end
        1: begin
          out_stall <= 1;
          stall_left <= $urandom_range(1, 8);
        end
        2: begin
          out_stall <= ($urandom_range(0, 1) == 1);
          stall_left <= $urandom_range(5, 30);
        end
        default: begin
          out_stall <= 1;
          stall_left <= $urandom_range(20, 30);
        end
      endcase
    end
  end

  // one input beat, held until taken
  task automatic send_beat(input logic f, input logic [11:0] gi, input logic [31:0] gx,
                           input logic [31:0] gy, input logic [11:0] px,
                           input logic [11:0] py);
    in_valid <= 1;
    func <= f;
    grid_index <= gi;
    grid_x_cm <= gx;
    grid_y_cm <= gy;
    pixel_x <= px;
    pixel_y <= py;
    do @(posedge clk); while (in_stall);
    sb.note_input(f, gi, gx, gy, px, py);
  endtask

  task automatic pause(input int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // sender bursts with random gaps between them
  int burst_left = 0;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20);
      pause($urandom_range(1, 6));
    end
  endtask

  // drain everything, then allow for load beats still inside the pipe
  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.want_x.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_geometry(input logic [20:0] ox, input logic [20:0] oy,
                                input logic [15:0] ivx, input logic [15:0] ivy,
                                input logic [6:0] nc, input logic [6:0] nr,
                                input logic [2:0] rc);
    logic [20:0] vals [7];
    vals = '{ox, oy, 21'(ivx), 21'(ivy), 21'(nc), 21'(nr), 21'(rc)};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_reg_t'(i), vals[i]);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] grid_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [20:0] ox, oy;
    logic [15:0] ivx, ivy;
    logic [6:0]  nc, nr;
    logic [2:0]  rc;
    int          rmax;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // fill the low grid points; every geometry below keeps cols * rows within them
    for (int i = 0; i < FILL_DEPTH; i++) begin
      send_beat(0, 12'(i), $urandom(), $urandom(), 12'($urandom()), 12'($urandom()));
      if ($urandom_range(0, 63) == 0) pause($urandom_range(1, 4));
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      ox = 21'($urandom()); oy = 21'($urandom());
      ivx = 16'($urandom_range(1, 65535)); ivy = 16'($urandom_range(1, 65535));
      nc = 7'($urandom_range(2, 64));
      rmax = FILL_DEPTH / int'(nc);
      if (rmax > 64) rmax = 64;
      nr = 7'($urandom_range(2, rmax));
      rc = 3'($urandom_range(0, 7));
      case (ph)
        0: begin ox = 0; oy = 0; ivx = 1024; ivy = 1024; nc = 64; nr = 4; rc = 1; end
        1: begin ox = 21'h100000; oy = 21'h0FFFFF; ivx = 16'hFFFF; ivy = 1;
                 nc = 2; nr = 2; rc = 4; end
        2: begin ox = -21'sd12800; oy = 21'd25600; ivx = 2048; ivy = 3000;
                 nc = 16; nr = 9; rc = 2; end
        3: begin ivx = 0; ivy = 0; nc = 0; nr = 1; rc = 4; end
        4: begin nc = 127; nr = 1; rc = 7; end
        5: begin ox = 0; oy = 0; ivx = 5000; ivy = 5000; nc = 3; nr = 3; rc = 4; end
        6: begin ox = 21'h0FFFFF; oy = 21'h100000; ivx = 300; ivy = 65535;
                 nc = 5; nr = 4; rc = 4; end
        7: begin rc = 0; end
        8: begin ivx = 16'hFFFF; ivy = 16'hFFFF; nc = 2; nr = 100; rc = 3; end
        default: ;
      endcase
      write_geometry(ox, oy, ivx, ivy, nc, nr, rc);

      // directed: saturated corner points, pixel extremes
      if (ph == 0) begin
        send_beat(0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0);
        send_beat(0, 1, 32'h80000000, 32'h7FFFFFFF, 0, 0);
        send_beat(0, 64, 32'h80000000, 32'h7FFFFFFF, 0, 0);
        send_beat(0, 65, 32'h7FFFFFFF, 32'h80000000, 0, 0);
      end
      send_beat(1, 0, 0, 0, 12'd0, 12'd0);
      send_beat(1, 0, 0, 0, 12'hFFF, 12'hFFF);
      send_beat(1, 0, 0, 0, 12'd0, 12'hFFF);
      send_beat(1, 0, 0, 0, 12'hFFF, 12'd0);
      send_beat(1, 12'hFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 12'd32, 12'd32);

      // random part: mostly maps, some grid reloads
      for (int k = 0; k < RANDOM_BEATS; k++) begin
        pace();
        if ($urandom_range(0, 5) == 0)
          send_beat(0, 12'($urandom()), grid_value(), grid_value(),
                    12'($urandom()), 12'($urandom()));
        else if ($urandom_range(0, 1) == 0)
          send_beat(1, 12'($urandom()), $urandom(), $urandom(),
                    12'($urandom()), 12'($urandom()));
        else
          send_beat(1, 12'($urandom()), $urandom(), $urandom(),
                    12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)));
        // hold off once per phase until all results are in
        if (k == RANDOM_BEATS / 2) wait_idle();
      end
    end

    wait_idle();
    $display("run: %0d grid loads and %0d pixel maps over %0d geometry settings, %0d matched",
             sb.loads, sb.maps, NUM_PHASES, sb.matched);
    if (sb.mismatches == 0 && sb.want_x.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("mismatches: %0d", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
